/* sv/cfde_pkg.sv */
// shared constants, command codes and controller/datapath interface types
`timescale 1ns / 1ps

package cfde_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PIX_DEPTH     = SCREEN_WIDTH * SCREEN_HEIGHT;

  // index widths derived from the geometry
  localparam int COL_W  = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int ROW_W  = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int ADDR_W = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;

  // field widths of one command beat
  localparam int ACT_W   = 3;
  localparam int POS_W   = 11;
  localparam int EXT_W   = 10;
  localparam int PIX_W   = 16;
  // signed width that holds any unclipped bound (pos + extent)
  localparam int COORD_W = 13;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COLS_C = coord_t'(SCREEN_WIDTH);
  localparam coord_t ROWS_C = coord_t'(SCREEN_HEIGHT);

  // action codes
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PIXEL   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_HLINE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_VLINE   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FILL    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_OUTLINE = 3'd5;
  localparam logic [ACT_W-1:0] ACT_READ    = 3'd6;
  localparam logic [ACT_W-1:0] ACT_NONE    = 3'd7;

  // outline segments: top, bottom, left, right
  localparam int SEG_W = 2;
  localparam logic [SEG_W-1:0] SEG_TOP    = 2'd0;
  localparam logic [SEG_W-1:0] SEG_BOTTOM = 2'd1;
  localparam logic [SEG_W-1:0] SEG_LEFT   = 2'd2;
  localparam logic [SEG_W-1:0] SEG_RIGHT  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic latch;     // capture the command beat
    logic init;      // with latch: capture a zero-color clear instead
    logic load;      // register clipped bounds of the current segment
    logic step;      // write one pixel and advance the raster counters
    logic seg_next;  // move to the next outline segment
    logic read;      // read the frame store at the latched position
    logic finish;    // present a result beat next cycle
    logic sel_read;  // with finish: result carries read data
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;     // current segment clips to nothing
    logic last_pix;  // counters sit on the last pixel of the segment
    logic last_seg;  // current segment is the last of the command
  } dp_status_t;

endpackage

/* sv/cfde_datapath.sv */
// datapath: command registers, clipping, raster counters, frame store, result registers
`timescale 1ns / 1ps

module cfde_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cfde_pkg::dp_cmd_t                     cmd,
  output cfde_pkg::dp_status_t                  status,
  input  logic [cfde_pkg::ACT_W-1:0]            action,
  input  logic signed [cfde_pkg::POS_W-1:0]     x_pos,
  input  logic signed [cfde_pkg::POS_W-1:0]     y_pos,
  input  logic [cfde_pkg::EXT_W-1:0]            width,
  input  logic [cfde_pkg::EXT_W-1:0]            height,
  input  logic [cfde_pkg::PIX_W-1:0]            color,
  output logic                                  done,
  output logic [cfde_pkg::PIX_W-1:0]            pixel_value,
  output logic                                  off_screen
);

  // latched command
  logic [cfde_pkg::ACT_W-1:0]        act;
  logic signed [cfde_pkg::POS_W-1:0] xr;
  logic signed [cfde_pkg::POS_W-1:0] yr;
  logic [cfde_pkg::EXT_W-1:0]        wr;
  logic [cfde_pkg::EXT_W-1:0]        hr;
  logic [cfde_pkg::PIX_W-1:0]        pen;
  logic [cfde_pkg::SEG_W-1:0]        seg;

  // segment bounds
  cfde_pkg::coord_t xs, ys, ws, hs, one;
  cfde_pkg::coord_t r0, r1, c0, c1;
  cfde_pkg::coord_t rl, rh, cl, ch, rh_m1, ch_m1;
  logic             seg_empty;

  // raster counters
  logic [cfde_pkg::ROW_W-1:0] row, row_last;
  logic [cfde_pkg::COL_W-1:0] col, col_first, col_last;
  logic                       empty;

  // frame store
  logic [cfde_pkg::PIX_W-1:0]  mem [cfde_pkg::PIX_DEPTH];
  logic [cfde_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [cfde_pkg::PIX_W-1:0]  rd_data;
  logic                        on_scr;

  // capture the command beat
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      if (cmd.init) begin
        act <= cfde_pkg::ACT_CLEAR;
        pen <= '0;
      end else begin
        act <= action;
        pen <= color;
      end
      xr  <= x_pos;
      yr  <= y_pos;
      wr  <= width;
      hr  <= height;
      seg <= cfde_pkg::SEG_TOP;
    end else if (cmd.seg_next) begin
      seg <= seg + 1'b1;
    end
  end

  // widen to the bound width
  assign xs  = cfde_pkg::coord_t'(xr);
  assign ys  = cfde_pkg::coord_t'(yr);
  assign ws  = cfde_pkg::coord_t'({{(cfde_pkg::COORD_W - cfde_pkg::EXT_W){1'b0}}, wr});
  assign hs  = cfde_pkg::coord_t'({{(cfde_pkg::COORD_W - cfde_pkg::EXT_W){1'b0}}, hr});
  assign one = cfde_pkg::coord_t'(1);

  // unclipped half-open row and column ranges of the current segment
  always_comb begin
    r0 = '0;
    r1 = '0;
    c0 = '0;
    c1 = '0;
    case (act)
      cfde_pkg::ACT_CLEAR: begin
        r1 = cfde_pkg::ROWS_C;
        c1 = cfde_pkg::COLS_C;
      end
      cfde_pkg::ACT_PIXEL: begin
        r0 = ys; r1 = ys + one; c0 = xs; c1 = xs + one;
      end
      cfde_pkg::ACT_HLINE: begin
        r0 = ys; r1 = ys + one; c0 = xs; c1 = xs + ws;
      end
      cfde_pkg::ACT_VLINE: begin
        r0 = ys; r1 = ys + hs; c0 = xs; c1 = xs + one;
      end
      cfde_pkg::ACT_FILL: begin
        r0 = ys; r1 = ys + hs; c0 = xs; c1 = xs + ws;
      end
      cfde_pkg::ACT_OUTLINE: begin
        case (seg)
          cfde_pkg::SEG_TOP: begin
            r0 = ys; r1 = ys + one; c0 = xs; c1 = xs + ws;
          end
          cfde_pkg::SEG_BOTTOM: begin
            r0 = ys + hs - one; r1 = ys + hs; c0 = xs; c1 = xs + ws;
          end
          cfde_pkg::SEG_LEFT: begin
            r0 = ys; r1 = ys + hs; c0 = xs; c1 = xs + one;
          end
          default: begin
            r0 = ys; r1 = ys + hs; c0 = xs + ws - one; c1 = xs + ws;
          end
        endcase
      end
      default: begin
        r0 = '0; r1 = '0; c0 = '0; c1 = '0;
      end
    endcase
  end

  // clip to the screen
  always_comb begin
    rl        = (r0 < 0) ? '0 : r0;
    rh        = (r1 > cfde_pkg::ROWS_C) ? cfde_pkg::ROWS_C : r1;
    cl        = (c0 < 0) ? '0 : c0;
    ch        = (c1 > cfde_pkg::COLS_C) ? cfde_pkg::COLS_C : c1;
    rh_m1     = rh - one;
    ch_m1     = ch - one;
    seg_empty = (rl >= rh) || (cl >= ch);
  end

  // raster counters: load a segment, then step through it row by row
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row       <= rl[cfde_pkg::ROW_W-1:0];
      row_last  <= rh_m1[cfde_pkg::ROW_W-1:0];
      col       <= cl[cfde_pkg::COL_W-1:0];
      col_first <= cl[cfde_pkg::COL_W-1:0];
      col_last  <= ch_m1[cfde_pkg::COL_W-1:0];
      empty     <= seg_empty;
    end else if (cmd.step) begin
      if (col == col_last) begin
        col <= col_first;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  assign status.empty    = empty;
  assign status.last_pix = (row == row_last) && (col == col_last);
  assign status.last_seg = (act != cfde_pkg::ACT_OUTLINE) || (seg == cfde_pkg::SEG_RIGHT);

  // addresses
  assign wr_addr = cfde_pkg::ADDR_W'(row) * cfde_pkg::ADDR_W'(cfde_pkg::SCREEN_WIDTH)
                 + cfde_pkg::ADDR_W'(col);
  assign rd_addr = cfde_pkg::ADDR_W'(yr[cfde_pkg::ROW_W-1:0])
                 * cfde_pkg::ADDR_W'(cfde_pkg::SCREEN_WIDTH)
                 + cfde_pkg::ADDR_W'(xr[cfde_pkg::COL_W-1:0]);
  assign on_scr  = (xs >= 0) && (xs < cfde_pkg::COLS_C) && (ys >= 0) && (ys < cfde_pkg::ROWS_C);

  // frame store write port
  always_ff @(posedge clk) begin
    if (cmd.step && !empty) begin
      mem[wr_addr] <= pen;
    end
  end

  // frame store read port
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data <= mem[rd_addr];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      pixel_value <= (cmd.sel_read && on_scr) ? rd_data : '0;
      off_screen  <= cmd.sel_read && !on_scr;
    end
  end

`ifndef SYNTH
  // a written pixel always lies inside the clipped column range
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !empty) |-> (col >= col_first && col <= col_last))
    else $error("write column outside clipped range");

  // an off-screen read never returns pixel data
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    (done && off_screen) |-> (pixel_value == '0))
    else $error("off-screen read returned nonzero data");
`endif

endmodule

/* sv/cfde_ctrl.sv */
// controller: command sequencing, segment loop and result timing
`timescale 1ns / 1ps

module cfde_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cfde_pkg::ACT_W-1:0] action,
  output logic                       busy,
  output cfde_pkg::dp_cmd_t          cmd,
  input  cfde_pkg::dp_status_t       status
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;

  logic [2:0] state, state_next;
  // set while the power-up zero fill runs, which gives no result
  logic       quiet, quiet_next;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    quiet_next = quiet;
    cmd        = '0;
    case (state)
      S_INIT: begin
        cmd.latch  = 1'b1;
        cmd.init   = 1'b1;
        state_next = S_LOAD;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          quiet_next = 1'b0;
          case (action)
            cfde_pkg::ACT_READ: state_next = S_READ;
            cfde_pkg::ACT_NONE: cmd.finish = 1'b1;
            default:            state_next = S_LOAD;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.step = !status.empty;
        if (status.empty || status.last_pix) begin
          if (status.last_seg) begin
            cmd.finish = !quiet;
            state_next = S_IDLE;
          end else begin
            cmd.seg_next = 1'b1;
            state_next   = S_LOAD;
          end
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_RDWAIT;
      end
      S_RDWAIT: begin
        cmd.finish   = 1'b1;
        cmd.sel_read = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      quiet <= 1'b1;
    end else begin
      state <= state_next;
      quiet <= quiet_next;
    end
  end

  assign busy = (state != S_IDLE);

`ifndef SYNTH
  // a read gives its result strobe request from S_RDWAIT, after passing through S_READ
  a_read_timing: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && action == cfde_pkg::ACT_READ) |=> ##1 cmd.finish)
    else $error("read result not issued on time");

  // every result request ends the command
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == S_IDLE))
    else $error("result issued before command end");
`endif

endmodule

/* sv/clipped_framebuffer_draw_engine_core.sv */
// top level: clipped rgb565 framebuffer draw engine
// draw command: busy through S_LOAD and S_SWEEP for each of its segments,
//   one segment per command and four for an outline; one pixel write per cycle in S_SWEEP
// read: done is registered after S_READ and S_RDWAIT; unused action: the next cycle
// draw/read: done rises as busy falls; one command at a time, the receiver cannot stall
// reset: synchronous; the frame store is then zero-filled while busy, with no result
`timescale 1ns / 1ps

module clipped_framebuffer_draw_engine_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [cfde_pkg::ACT_W-1:0]        action,
  input  logic signed [cfde_pkg::POS_W-1:0] x_pos,
  input  logic signed [cfde_pkg::POS_W-1:0] y_pos,
  input  logic [cfde_pkg::EXT_W-1:0]        width,
  input  logic [cfde_pkg::EXT_W-1:0]        height,
  input  logic [cfde_pkg::PIX_W-1:0]        color,
  output logic                              done,
  output logic [cfde_pkg::PIX_W-1:0]        pixel_value,
  output logic                              off_screen
);

  cfde_pkg::dp_cmd_t    cmd;
  cfde_pkg::dp_status_t status;

  // sequencer
  cfde_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // clipping, raster walk and frame store
  cfde_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .action      (action),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .width       (width),
    .height      (height),
    .color       (color),
    .done        (done),
    .pixel_value (pixel_value),
    .off_screen  (off_screen)
  );

endmodule
